### rtl/aie_pkg.sv
// Shared types and constants for the instruction encoder.
// No dependencies; imported by aie_front, aie_back and the top level.
package aie_pkg;

	typedef enum logic [4:0] {
		CMD_ADD   = 5'd0,
		CMD_SUB   = 5'd1,
		CMD_RSB   = 5'd2,
		CMD_AND   = 5'd3,
		CMD_EOR   = 5'd4,
		CMD_ORR   = 5'd5,
		CMD_MOV   = 5'd6,
		CMD_TST   = 5'd7,
		CMD_TEQ   = 5'd8,
		CMD_CMP   = 5'd9,
		CMD_MUL   = 5'd10,
		CMD_MLA   = 5'd11,
		CMD_LDR   = 5'd12,
		CMD_STR   = 5'd13,
		CMD_BEQ   = 5'd14,
		CMD_BNE   = 5'd15,
		CMD_BGE   = 5'd16,
		CMD_BLT   = 5'd17,
		CMD_BGT   = 5'd18,
		CMD_BLE   = 5'd19,
		CMD_B     = 5'd20,
		CMD_LSL   = 5'd21,
		CMD_ANDEQ = 5'd22
	} cmd_t;

	localparam logic [1:0] MODE_BASE = 2'd0;
	localparam logic [1:0] MODE_PRE  = 2'd1;
	localparam logic [1:0] MODE_POST = 2'd2;
	localparam logic [1:0] MODE_LIT  = 2'd3;

	localparam logic [2:0] SH_NONE = 3'd0;
	localparam logic [2:0] SH_LSL  = 3'd1;
	localparam logic [2:0] SH_LSR  = 3'd2;
	localparam logic [2:0] SH_ASR  = 3'd3;
	localparam logic [2:0] SH_ROR  = 3'd4;

	localparam logic [3:0] COND_AL     = 4'd14;
	localparam logic [3:0] MUL_MARK    = 4'd9;
	localparam logic [2:0] BRANCH_MARK = 3'd5;
	localparam logic [7:0] BYTE_MASK   = 8'hFF;
	localparam logic [3:0] PC_REG      = 4'd15;
	localparam logic [3:0] DP_MOV      = 4'd13;
	localparam int         OFFSET_BITS = 12;
	localparam int         LIT_CNT_W   = 14;
	localparam int         PROG_LEN_W  = 15;

	// APB register map (word index)
	localparam logic REG_PROG_LEN = 1'b0;

	// one encoded request as it sits in the queue
	typedef struct packed {
		logic        lit;
		logic        err;
		logic [31:0] word;
		logic [31:0] lit_word;
	} item_t;

endpackage

### rtl/aie_item_if.sv
// Input channel: one parsed instruction per request, valid/ready handshake.
// Depends on nothing; ADDRESS_BITS sets the width of current_address.
interface aie_item_if #(parameter int ADDRESS_BITS = 16);
	logic                    valid;
	logic                    ready;
	logic [4:0]              cmd;
	logic [3:0]              rd;
	logic [3:0]              rn;
	logic [3:0]              rm;
	logic [3:0]              rs;
	logic                    op2_imm;
	logic [31:0]             imm_value;
	logic                    negative;
	logic [2:0]              shift_type;
	logic                    shift_by_reg;
	logic [1:0]              addr_mode;
	logic [ADDRESS_BITS-1:0] current_address;

	modport source (
		output valid, cmd, rd, rn, rm, rs, op2_imm, imm_value, negative,
			shift_type, shift_by_reg, addr_mode, current_address,
		input  ready
	);
	modport sink (
		input  valid, cmd, rd, rn, rm, rs, op2_imm, imm_value, negative,
			shift_type, shift_by_reg, addr_mode, current_address,
		output ready
	);
endinterface

### rtl/aie_result_if.sv
// Output channel: one encoded word per request, valid/ready handshake.
// Depends on nothing.
interface aie_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] instr_word;
	logic        literal_valid;
	logic [31:0] literal_word;
	logic        imm_error;

	modport source (
		output valid, instr_word, literal_valid, literal_word, imm_error,
		input  ready
	);
	modport sink (
		input  valid, instr_word, literal_valid, literal_word, imm_error,
		output ready
	);
endinterface

### rtl/aie_queue.sv
// Small register FIFO between the encode front and the literal back end.
// Depends on nothing; DEPTH must be a power of two, at least 2.
module aie_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output logic             empty
);
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PW'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + PW'(1);
			if (push && !pop) count_q <= count_q + CW'(1);
			else if (pop && !push) count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

### rtl/aie_front.sv
// Encode front: takes a parsed instruction and builds its machine word,
// including the rotated-immediate search. Depends on aie_pkg, aie_item_if.
module aie_front
	import aie_pkg::*;
#(
	parameter int ADDRESS_BITS = 16
) (
	aie_item_if.sink                in_ch,
	input  logic                    full,
	output logic                    push,
	output item_t                   item,
	output logic [ADDRESS_BITS-1:0] cur
);
	logic [11:0] rot_field;
	logic        rot_err;
	logic [31:0] rb;
	logic [11:0] sh_field;
	logic [3:0]  opc;
	logic [3:0]  f_rn;
	logic [3:0]  f_rd;
	logic        s_bit;
	logic [11:0] op2;
	logic [31:0] diff;
	logic        up;
	logic        pre;
	logic        i_bit;
	logic [11:0] xoff;

	assign in_ch.ready = !full;
	assign push        = in_ch.valid && !full;
	assign cur         = in_ch.current_address;

	// smallest even rotation that brings the value into one byte
	always_comb begin
		rot_field = {4'd0, in_ch.imm_value[7:0]};
		rot_err   = 1'b1;
		rb        = '0;
		for (int r = 15; r >= 1; r--) begin
			rb = (in_ch.imm_value << (2 * r)) | (in_ch.imm_value >> (32 - 2 * r));
			if (rb[31:8] == 24'd0) begin
				rot_field = {4'(r), rb[7:0]};
				rot_err   = 1'b0;
			end
		end
		if (in_ch.imm_value[31:8] == 24'd0) begin
			rot_field = {4'd0, in_ch.imm_value[7:0]};
			rot_err   = 1'b0;
		end
	end

	// register operand with optional shift; unknown shift types mean none
	always_comb begin
		sh_field = {8'd0, in_ch.rm};
		if (in_ch.shift_type >= SH_LSL && in_ch.shift_type <= SH_ROR) begin
			if (in_ch.shift_by_reg)
				sh_field = {in_ch.rs, 1'b0, 2'(in_ch.shift_type - SH_LSL), 1'b1, in_ch.rm};
			else
				sh_field = {in_ch.imm_value[4:0], 2'(in_ch.shift_type - SH_LSL), 1'b0,
					in_ch.rm};
		end
	end

	assign diff = in_ch.imm_value - 32'(in_ch.current_address) - 32'd8;
	assign op2  = in_ch.op2_imm ? rot_field : sh_field;

	always_comb begin
		case (in_ch.cmd)
			CMD_ADD: opc = 4'd4;
			CMD_SUB: opc = 4'd2;
			CMD_RSB: opc = 4'd3;
			CMD_AND: opc = 4'd0;
			CMD_EOR: opc = 4'd1;
			CMD_ORR: opc = 4'd12;
			CMD_MOV: opc = DP_MOV;
			CMD_TST: opc = 4'd8;
			CMD_TEQ: opc = 4'd9;
			CMD_CMP: opc = 4'd10;
			CMD_BEQ: opc = 4'd0;
			CMD_BNE: opc = 4'd1;
			CMD_BGE: opc = 4'd10;
			CMD_BLT: opc = 4'd11;
			CMD_BGT: opc = 4'd12;
			CMD_BLE: opc = 4'd13;
			CMD_B:   opc = COND_AL;
			default: opc = 4'd0;
		endcase
	end

	// field placement for the three data-processing shapes
	always_comb begin
		f_rn  = in_ch.rn;
		f_rd  = in_ch.rd;
		s_bit = 1'b0;
		if (in_ch.cmd == CMD_MOV) begin
			f_rn = 4'd0;
		end else if (in_ch.cmd > CMD_MOV) begin
			f_rn  = in_ch.rd;
			f_rd  = 4'd0;
			s_bit = 1'b1;
		end
	end

	// transfer addressing bits
	always_comb begin
		up    = 1'b1;
		pre   = (in_ch.addr_mode != MODE_POST);
		i_bit = 1'b0;
		xoff  = '0;
		if (in_ch.addr_mode == MODE_PRE || in_ch.addr_mode == MODE_POST) begin
			up = !in_ch.negative;
			if (in_ch.op2_imm) begin
				xoff = in_ch.imm_value[OFFSET_BITS-1:0];
			end else begin
				i_bit = 1'b1;
				xoff  = sh_field;
			end
		end
	end

	always_comb begin
		item = '0;
		if (in_ch.cmd == CMD_LDR && in_ch.addr_mode == MODE_LIT
				&& in_ch.imm_value[31:8] == 24'd0) begin
			// small literal load turns into mov rd, #value
			item.word = {COND_AL, 3'b001, DP_MOV, 1'b0, 4'd0, in_ch.rd, 4'd0,
				in_ch.imm_value[7:0]};
		end else begin
			case (in_ch.cmd)
				CMD_ADD, CMD_SUB, CMD_RSB, CMD_AND, CMD_EOR, CMD_ORR, CMD_MOV,
				CMD_TST, CMD_TEQ, CMD_CMP: begin
					item.word = {COND_AL, 2'b00, in_ch.op2_imm, opc, s_bit, f_rn, f_rd, op2};
					item.err  = in_ch.op2_imm && rot_err;
				end
				CMD_MUL, CMD_MLA: begin
					item.word = {COND_AL, 6'd0, (in_ch.cmd == CMD_MLA), 1'b0, in_ch.rd,
						(in_ch.cmd == CMD_MLA) ? in_ch.rn : 4'd0, in_ch.rs, MUL_MARK,
						in_ch.rm};
				end
				CMD_LDR, CMD_STR: begin
					if (in_ch.cmd == CMD_LDR && in_ch.addr_mode == MODE_LIT) begin
						// pool offset is filled in by the back end
						item.lit      = 1'b1;
						item.lit_word = in_ch.imm_value;
						item.word     = {COND_AL, 2'b01, 1'b0, 1'b1, 1'b1, 2'b00, 1'b1,
							PC_REG, in_ch.rd, 12'd0};
					end else begin
						item.word = {COND_AL, 2'b01, i_bit, pre, up, 2'b00,
							(in_ch.cmd == CMD_LDR), in_ch.rn, in_ch.rd, xoff};
						item.err  = (in_ch.addr_mode == MODE_PRE || in_ch.addr_mode == MODE_POST)
							&& in_ch.op2_imm && (in_ch.imm_value[31:OFFSET_BITS] != '0);
					end
				end
				CMD_BEQ, CMD_BNE, CMD_BGE, CMD_BLT, CMD_BGT, CMD_BLE, CMD_B: begin
					item.word = {opc, BRANCH_MARK, 1'b0, diff[25:2]};
				end
				CMD_LSL: begin
					item.word = {COND_AL, 3'b000, DP_MOV, 1'b0, 4'd0, in_ch.rd,
						in_ch.shift_by_reg ? {in_ch.rs, 4'b0001} : {in_ch.imm_value[4:0], 3'b000},
						in_ch.rd};
				end
				default: item = '0;
			endcase
		end
	end

endmodule

### rtl/aie_back.sv
// Back end: keeps the literal-pool count, patches pc-relative offsets and
// holds the result register. Depends on aie_pkg, aie_result_if.
module aie_back
	import aie_pkg::*;
#(
	parameter int ADDRESS_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  item_t                   head,
	input  logic [ADDRESS_BITS-1:0] head_cur,
	input  logic                    empty,
	input  logic [PROG_LEN_W-1:0]   program_length,
	output logic                    pop,
	aie_result_if.source            out_ch
);
	localparam int QW    = LIT_CNT_W + 4;
	localparam int OFF_W = ((ADDRESS_BITS > QW) ? ADDRESS_BITS : QW) + 2;

	logic [LIT_CNT_W-1:0] lit_count_q;
	logic [LIT_CNT_W-1:0] next_count;
	logic [QW-3:0]        pool_idx;
	logic [OFF_W-1:0]     off;
	logic                 off_err;
	logic                 out_valid_q;
	logic [31:0]          word_q;
	logic                 lit_q;
	logic [31:0]          lit_word_q;
	logic                 err_q;

	assign pop        = !empty && (!out_valid_q || out_ch.ready);
	assign next_count = lit_count_q + LIT_CNT_W'(1);
	assign pool_idx   = (QW-2)'(next_count) + (QW-2)'(program_length);
	// offset = (count + 1 + length) * 4 - address - 12
	assign off        = OFF_W'({pool_idx, 2'b00}) - OFF_W'(head_cur) - OFF_W'(12);
	assign off_err    = off[OFF_W-1] || (off[OFF_W-2:OFFSET_BITS] != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lit_count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && head.lit) lit_count_q <= next_count;
			if (pop) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			word_q     <= head.lit ? (head.word | 32'(off[OFFSET_BITS-1:0])) : head.word;
			lit_q      <= head.lit;
			lit_word_q <= head.lit_word;
			err_q      <= head.err || (head.lit && off_err);
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.instr_word    = word_q;
	assign out_ch.literal_valid = lit_q;
	assign out_ch.literal_word  = lit_word_q;
	assign out_ch.imm_error     = err_q;

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.lit) |=> (lit_count_q == $past(next_count)))
		else $error("literal count did not advance on pool request");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && head.lit) |=> $stable(lit_count_q))
		else $error("literal count moved without a pool request");

	a_lit_pc: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && lit_q) |-> (word_q[19:16] == PC_REG))
		else $error("pool load not pc-relative");

	a_no_pop_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ch.ready) |-> !pop)
		else $error("result register overwritten while stalled");

endmodule

### rtl/armv4_instruction_encoder_top.sv
// Instruction encoder: one request in, one encoded word out.
// An accepted request is registered in the queue, then in the result register (front -> queue, queue -> result reg).
// Throughput one request per cycle while out_ch.ready stays high; the queue lets input and output stall independently.
// Reset empties the queue and clears the result valid flag, the literal count and program_length.
// Depends on aie_pkg, aie_item_if, aie_result_if, aie_queue, aie_front, aie_back.
module armv4_instruction_encoder_top
	import aie_pkg::*;
#(
	parameter int ADDRESS_BITS = 16,
	parameter int QUEUE_DEPTH  = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	aie_item_if.sink    in_ch,
	aie_result_if.source out_ch
);
	localparam int QDW = $bits(item_t) + ADDRESS_BITS;

	logic [PROG_LEN_W-1:0]   program_length_q;
	logic                    push;
	logic                    full;
	logic                    pop;
	logic                    empty;
	item_t                   f_item;
	logic [ADDRESS_BITS-1:0] f_cur;
	logic [QDW-1:0]          q_head;
	item_t                   b_item;
	logic [ADDRESS_BITS-1:0] b_cur;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_PROG_LEN) ? 32'(program_length_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			program_length_q <= '0;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_PROG_LEN) begin
			program_length_q <= pwdata[PROG_LEN_W-1:0];
		end
	end

	aie_front #(.ADDRESS_BITS(ADDRESS_BITS)) u_front (
		.in_ch (in_ch),
		.full  (full),
		.push  (push),
		.item  (f_item),
		.cur   (f_cur)
	);

	aie_queue #(.WIDTH(QDW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({f_cur, f_item}),
		.full      (full),
		.pop       (pop),
		.head      (q_head),
		.empty     (empty)
	);

	assign b_item = q_head[$bits(item_t)-1:0];
	assign b_cur  = q_head[QDW-1:$bits(item_t)];

	aie_back #(.ADDRESS_BITS(ADDRESS_BITS)) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (b_item),
		.head_cur       (b_cur),
		.empty          (empty),
		.program_length (program_length_q),
		.pop            (pop),
		.out_ch         (out_ch)
	);

endmodule
